[rtl/core/dsvb_pkg.sv]
// Shared types and constants for the depth splat visibility buffer.
package dsvb_pkg;

  localparam int unsigned CoordW   = 14;
  localparam int unsigned RadiusW  = 12;
  localparam int unsigned InDepthW = 32;
  localparam int unsigned SizeW    = 11;
  localparam int unsigned RelW     = 16;
  localparam int unsigned AbsW     = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RsqW     = 2 * RadiusW;

  typedef enum logic [1:0] {
    CMD_CLEAR         = 2'd0,
    CMD_SPLAT_STATIC  = 2'd1,
    CMD_SPLAT_DYNAMIC = 2'd2,
    CMD_TEST          = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH     = 3'd0,
    CFG_IMAGE_HEIGHT    = 3'd1,
    CFG_STATIC_REL_TOL  = 3'd2,
    CFG_STATIC_ABS_TOL  = 3'd3,
    CFG_DYNAMIC_REL_TOL = 3'd4,
    CFG_DYNAMIC_ABS_TOL = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SQUARE,
    ST_CRD,
    ST_CWR,
    ST_PRD,
    ST_PWR,
    ST_TRD,
    ST_TMUL,
    ST_TCMP,
    ST_TOUT
  } state_e;

  typedef struct packed {
    logic [InDepthW-1:0] z;
    logic [RelW-1:0]     rel;
    logic [AbsW-1:0]     abs_tol;
    logic [InDepthW-1:0] depth;
  } gate_req_t;

endpackage

[rtl/core/dsvb_gate.sv]
// Two-stage depth gate: tolerance multiply, then add and compare.
module dsvb_gate (
  input  logic                clk_i,
  input  logic                load_i,
  input  dsvb_pkg::gate_req_t req_i,
  output logic                pass_o
);

  localparam int unsigned ProdW = dsvb_pkg::InDepthW + 17;
  localparam int unsigned SumW  = ProdW + 1;

  logic [ProdW-1:0]            prod_q;
  logic [dsvb_pkg::AbsW-1:0]   abs_q;
  logic [dsvb_pkg::InDepthW-1:0] depth_q;
  logic [SumW-1:0]             lhs;
  logic [SumW-1:0]             rhs;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q  <= ProdW'(req_i.z) * ProdW'({1'b1, req_i.rel});
      abs_q   <= req_i.abs_tol;
      depth_q <= req_i.depth;
    end
  end

  assign lhs    = SumW'({depth_q, 16'h0000});
  assign rhs    = SumW'(prod_q) + SumW'({abs_q, 16'h0000});
  assign pass_o = (lhs <= rhs);

endmodule

[rtl/core/depth_splat_visibility_buffer.sv]
// Depth splat visibility buffer: static and dynamic depth memories, splat and test engine.
// Each command is taken alone: the input stalls until the previous one has finished.
// After reset and after every clear command the block sweeps all MAX_WIDTH*MAX_HEIGHT
// entries of both memories, one entry a cycle; configuration writes are still taken meanwhile.
// A splat on the image reads and writes its centre pixel, then reads and writes each
// pixel of its clamped bounding box in turn; a splat off the image ends after setup.
// A test on the image runs the read, the tolerance multiply and the compare, a test off
// the image goes straight from setup to the output; both may wait on the output register.
module depth_splat_visibility_buffer #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned Z_BITS     = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         command_i,
  input  logic [dsvb_pkg::CoordW-1:0]        u_pos_i,
  input  logic [dsvb_pkg::CoordW-1:0]        v_pos_i,
  input  logic [dsvb_pkg::RadiusW-1:0]       radius_i,
  input  logic [dsvb_pkg::InDepthW-1:0]      depth_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               visible_o,
  output logic                               occluder_source_o,
  input  logic                               cfg_we_i,
  input  logic [dsvb_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [dsvb_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned Cells = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned CW    = ((XW > YW) ? XW : YW) + 6;
  localparam int unsigned SQW   = 2 * CW;
  localparam logic [Z_BITS-1:0] EmptyMark = {Z_BITS{1'b1}};
  localparam logic [31:0] SatDepth = 32'((64'd1 << Z_BITS) - 64'd2);

  dsvb_pkg::state_e state_q, state_d;

  logic [dsvb_pkg::SizeW-1:0] width_q, height_q;
  logic [dsvb_pkg::RelW-1:0]  srel_q, drel_q;
  logic [dsvb_pkg::AbsW-1:0]  sabs_q, dabs_q;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  logic [1:0]                   cmd_q;
  logic [dsvb_pkg::CoordW-1:0]  u_q, v_q;
  logic [dsvb_pkg::RadiusW-1:0] r_q;
  logic [Z_BITS-1:0]            d_q;

  logic [XW-1:0] x0_q, x1_q, cx_q, px_q;
  logic [YW-1:0] y0_q, y1_q, cy_q, py_q;
  logic signed [CW-1:0] dx0_q, dy0_q, dx_q, dy_q;
  logic [SQW-1:0] dx0sq_q, dy0sq_q, dxsq_q, dysq_q;
  logic [dsvb_pkg::RsqW-1:0] rsq_q;
  logic box_en_q;
  logic [AW-1:0] center_addr_q, row_q, addr_q, clr_q;

  logic [Z_BITS-1:0] mem_s [Cells];
  logic [Z_BITS-1:0] mem_d [Cells];
  logic [Z_BITS-1:0] rd_s_q, rd_d_q, rd_sel;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [Z_BITS-1:0] wr_data;
  logic we_s, we_d, wr_en;

  logic use_dyn_q, st_empty_q, res_vis_q, res_src_q;
  logic out_valid_q, vis_q, src_q;
  logic gate_load, gate_pass, out_load;
  dsvb_pkg::gate_req_t gate_req;

  logic in_acc, is_dyn, in_disc, last_px, last_py;
  logic [31:0] x0c, x1c, y0c, y1c, x0raw, x1raw, y0raw, y1raw;
  logic [dsvb_pkg::CoordW-1:0] r14;
  logic on_img, box_en;
  logic signed [CW-1:0] dx0, dy0;
  logic signed [SQW-1:0] dx0_ext, dy0_ext, dx_ext, dy_ext;
  logic [AW-1:0] cy_ext, y0_ext, w_ext;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dsvb_pkg::SizeW'(1024);
      height_q <= dsvb_pkg::SizeW'(1024);
      srel_q   <= '0;
      sabs_q   <= '0;
      drel_q   <= '0;
      dabs_q   <= '0;
    end else if (cfg_we_i) begin
      case (dsvb_pkg::cfg_idx_e'(cfg_index_i))
        dsvb_pkg::CFG_IMAGE_WIDTH:     width_q  <= cfg_data_i[dsvb_pkg::SizeW-1:0];
        dsvb_pkg::CFG_IMAGE_HEIGHT:    height_q <= cfg_data_i[dsvb_pkg::SizeW-1:0];
        dsvb_pkg::CFG_STATIC_REL_TOL:  srel_q   <= cfg_data_i[dsvb_pkg::RelW-1:0];
        dsvb_pkg::CFG_STATIC_ABS_TOL:  sabs_q   <= cfg_data_i[dsvb_pkg::AbsW-1:0];
        dsvb_pkg::CFG_DYNAMIC_REL_TOL: drel_q   <= cfg_data_i[dsvb_pkg::RelW-1:0];
        dsvb_pkg::CFG_DYNAMIC_ABS_TOL: dabs_q   <= cfg_data_i[dsvb_pkg::AbsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_q);
    end
  end

  assign in_stall_o = (state_q != dsvb_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_dyn     = (dsvb_pkg::cmd_e'(cmd_q) == dsvb_pkg::CMD_SPLAT_DYNAMIC);

  // box geometry, in sixteenths of a pixel
  assign r14    = dsvb_pkg::CoordW'(r_q);
  assign on_img = (32'(u_q[dsvb_pkg::CoordW-1:4]) < 32'(eff_w)) &&
                  (32'(v_q[dsvb_pkg::CoordW-1:4]) < 32'(eff_h));

  always_comb begin
    x0raw = (u_q <= r14) ? 32'd0 : ((32'(u_q) - 32'(r14) + 32'd15) >> 4);
    y0raw = (v_q <= r14) ? 32'd0 : ((32'(v_q) - 32'(r14) + 32'd15) >> 4);
    x1raw = (32'(u_q) + 32'(r14)) >> 4;
    y1raw = (32'(v_q) + 32'(r14)) >> 4;
    x0c   = x0raw;
    y0c   = y0raw;
    x1c   = (x1raw > 32'(eff_w) - 32'd1) ? 32'(eff_w) - 32'd1 : x1raw;
    y1c   = (y1raw > 32'(eff_h) - 32'd1) ? 32'(eff_h) - 32'd1 : y1raw;
  end

  assign box_en = (r_q != '0) && (x0c <= x1c) && (y0c <= y1c);
  assign dx0 = CW'(signed'({1'b0, x0c[XW-1:0], 4'b0000})) - CW'(signed'({1'b0, u_q}));
  assign dy0 = CW'(signed'({1'b0, y0c[YW-1:0], 4'b0000})) - CW'(signed'({1'b0, v_q}));

  assign dx0_ext = SQW'(dx0_q);
  assign dy0_ext = SQW'(dy0_q);
  assign dx_ext  = SQW'(dx_q);
  assign dy_ext  = SQW'(dy_q);
  assign cy_ext  = AW'(cy_q);
  assign y0_ext  = AW'(y0_q);
  assign w_ext   = AW'(eff_w);

  assign in_disc = (64'(dxsq_q) + 64'(dysq_q)) <= 64'(rsq_q);
  assign last_px = (px_q == x1_q);
  assign last_py = (py_q == y1_q);
  assign rd_sel  = is_dyn ? rd_d_q : rd_s_q;

  // next state and memory control
  always_comb begin
    state_d   = state_q;
    wr_en     = 1'b0;
    gate_load = 1'b0;
    out_load  = 1'b0;
    rd_addr   = center_addr_q;
    wr_addr   = addr_q;
    wr_data   = d_q;
    case (state_q)
      dsvb_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = EmptyMark;
        if (clr_q == AW'(Cells - 1)) begin
          state_d = dsvb_pkg::ST_IDLE;
        end
      end
      dsvb_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (dsvb_pkg::cmd_e'(command_i) == dsvb_pkg::CMD_CLEAR) ?
                    dsvb_pkg::ST_CLEAR : dsvb_pkg::ST_SETUP;
        end
      end
      dsvb_pkg::ST_SETUP: begin
        if (on_img) begin
          state_d = dsvb_pkg::ST_SQUARE;
        end else if (dsvb_pkg::cmd_e'(cmd_q) == dsvb_pkg::CMD_TEST) begin
          state_d = dsvb_pkg::ST_TOUT;
        end else begin
          state_d = dsvb_pkg::ST_IDLE;
        end
      end
      dsvb_pkg::ST_SQUARE: begin
        state_d = (dsvb_pkg::cmd_e'(cmd_q) == dsvb_pkg::CMD_TEST) ?
                  dsvb_pkg::ST_TRD : dsvb_pkg::ST_CRD;
      end
      dsvb_pkg::ST_CRD: begin
        state_d = dsvb_pkg::ST_CWR;
      end
      dsvb_pkg::ST_CWR: begin
        wr_addr = center_addr_q;
        wr_en   = (d_q < rd_sel);
        state_d = box_en_q ? dsvb_pkg::ST_PRD : dsvb_pkg::ST_IDLE;
      end
      dsvb_pkg::ST_PRD: begin
        rd_addr = addr_q;
        state_d = dsvb_pkg::ST_PWR;
      end
      dsvb_pkg::ST_PWR: begin
        wr_en   = in_disc && (d_q < rd_sel);
        state_d = (last_px && last_py) ? dsvb_pkg::ST_IDLE : dsvb_pkg::ST_PRD;
      end
      dsvb_pkg::ST_TRD: begin
        state_d = dsvb_pkg::ST_TMUL;
      end
      dsvb_pkg::ST_TMUL: begin
        gate_load = 1'b1;
        state_d   = dsvb_pkg::ST_TCMP;
      end
      dsvb_pkg::ST_TCMP: begin
        state_d = dsvb_pkg::ST_TOUT;
      end
      dsvb_pkg::ST_TOUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = dsvb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dsvb_pkg::ST_IDLE;
      end
    endcase
  end

  assign we_s = wr_en && ((state_q == dsvb_pkg::ST_CLEAR) || !is_dyn);
  assign we_d = wr_en && ((state_q == dsvb_pkg::ST_CLEAR) || is_dyn);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsvb_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= (state_q == dsvb_pkg::ST_CLEAR) ? clr_q + AW'(1) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_s) begin
      mem_s[wr_addr] <= wr_data;
    end
    if (we_d) begin
      mem_d[wr_addr] <= wr_data;
    end
    rd_s_q <= mem_s[rd_addr];
    rd_d_q <= mem_d[rd_addr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      dsvb_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_q <= command_i;
          u_q   <= u_pos_i;
          v_q   <= v_pos_i;
          r_q   <= radius_i;
          d_q   <= Z_BITS'((depth_i > SatDepth) ? SatDepth : depth_i);
        end
      end
      dsvb_pkg::ST_SETUP: begin
        x0_q      <= XW'(x0c);
        x1_q      <= XW'(x1c);
        y0_q      <= YW'(y0c);
        y1_q      <= YW'(y1c);
        cx_q      <= XW'(u_q[dsvb_pkg::CoordW-1:4]);
        cy_q      <= YW'(v_q[dsvb_pkg::CoordW-1:4]);
        dx0_q     <= dx0;
        dy0_q     <= dy0;
        box_en_q  <= box_en;
        res_vis_q <= 1'b0;
        res_src_q <= 1'b0;
      end
      dsvb_pkg::ST_SQUARE: begin
        center_addr_q <= cy_ext * w_ext + AW'(cx_q);
        row_q         <= y0_ext * w_ext;
        dx0sq_q       <= SQW'(dx0_ext * dx0_ext);
        dy0sq_q       <= SQW'(dy0_ext * dy0_ext);
        rsq_q         <= dsvb_pkg::RsqW'(r_q) * dsvb_pkg::RsqW'(r_q);
      end
      dsvb_pkg::ST_CWR: begin
        px_q   <= x0_q;
        py_q   <= y0_q;
        dx_q   <= dx0_q;
        dy_q   <= dy0_q;
        dxsq_q <= dx0sq_q;
        dysq_q <= dy0sq_q;
        addr_q <= row_q + AW'(x0_q);
      end
      dsvb_pkg::ST_PWR: begin
        if (last_px) begin
          py_q   <= py_q + YW'(1);
          dy_q   <= dy_q + CW'(16);
          dysq_q <= dysq_q + SQW'(dy_ext <<< 5) + SQW'(256);
          px_q   <= x0_q;
          dx_q   <= dx0_q;
          dxsq_q <= dx0sq_q;
          row_q  <= row_q + w_ext;
          addr_q <= row_q + w_ext + AW'(x0_q);
        end else begin
          px_q   <= px_q + XW'(1);
          dx_q   <= dx_q + CW'(16);
          dxsq_q <= dxsq_q + SQW'(dx_ext <<< 5) + SQW'(256);
          addr_q <= addr_q + AW'(1);
        end
      end
      dsvb_pkg::ST_TMUL: begin
        use_dyn_q  <= (rd_d_q != EmptyMark);
        st_empty_q <= (rd_s_q == EmptyMark);
      end
      dsvb_pkg::ST_TCMP: begin
        res_vis_q <= (!use_dyn_q && st_empty_q) ? 1'b1 : gate_pass;
        res_src_q <= use_dyn_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    gate_req.depth = 32'(d_q);
    if (rd_d_q != EmptyMark) begin
      gate_req.z       = 32'(rd_d_q);
      gate_req.rel     = drel_q;
      gate_req.abs_tol = dabs_q;
    end else begin
      gate_req.z       = 32'(rd_s_q);
      gate_req.rel     = srel_q;
      gate_req.abs_tol = sabs_q;
    end
  end

  dsvb_gate u_gate (
    .clk_i  (clk_i),
    .load_i (gate_load),
    .req_i  (gate_req),
    .pass_o (gate_pass)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      vis_q <= res_vis_q;
      src_q <= res_src_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign visible_o         = vis_q;
  assign occluder_source_o = src_q;

endmodule

[rtl/core/dsvb_checker.sv]
// Port-level checks for the depth splat visibility buffer, bound to the top level.
module dsvb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] command_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       visible_o,
  input logic       occluder_source_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(visible_o) &&
    $stable(occluder_source_o))
    else $error("stalled result changed");

  // sweep the memories right after reset
  a_reset_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input open during reset sweep");

  // busy after every transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input open right after a transaction");

  // a result only follows work in progress
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a pending test");

  // clear never answers
  a_clear_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (dsvb_pkg::cmd_e'(command_i) == dsvb_pkg::CMD_CLEAR) ##1 !out_valid_o
    |=> !out_valid_o)
    else $error("result after clear");

endmodule

bind depth_splat_visibility_buffer dsvb_checker u_dsvb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .command_i         (command_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .visible_o         (visible_o),
  .occluder_source_o (occluder_source_o)
);

[dv/tb_depth_splat_visibility_buffer.sv]
// Self-checking testbench for the depth splat visibility buffer: splat, clear and test traffic.
`timescale 1ns / 1ps

module tb_depth_splat_visibility_buffer;

  localparam int unsigned MaxW = 1024;
  localparam int unsigned MaxH = 1024;
  localparam logic [31:0] EmptyMark = 32'hFFFF_FFFF;

  typedef struct packed {
    dsvb_pkg::cmd_e                command;
    logic [dsvb_pkg::CoordW-1:0]   u_pos;
    logic [dsvb_pkg::CoordW-1:0]   v_pos;
    logic [dsvb_pkg::RadiusW-1:0]  radius;
    logic [dsvb_pkg::InDepthW-1:0] depth;
  } point_cmd_t;

  typedef struct packed {
    logic visible;
    logic occluder_source;
  } vis_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  point_cmd_t drv_cmd = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  logic visible_o;
  logic occluder_source_o;
  logic cfg_we = 1'b0;
  dsvb_pkg::cfg_idx_e cfg_index = dsvb_pkg::CFG_IMAGE_WIDTH;
  logic [dsvb_pkg::CfgDataW-1:0] cfg_data = '0;

  point_cmd_t pending_cmds[$];
  vis_result_t expected_vis[$];
  logic [31:0] static_z[int unsigned];
  logic [31:0] dynamic_z[int unsigned];

  logic [10:0] width_reg = 11'd1024;
  logic [10:0] height_reg = 11'd1024;
  logic [15:0] srel_reg = '0;
  logic [31:0] sabs_reg = '0;
  logic [15:0] drel_reg = '0;
  logic [31:0] dabs_reg = '0;

  int snd_idle = 0;
  int rcv_idle = 0;
  int rcv_hold = 0;
  int errors = 0;

  depth_splat_visibility_buffer uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o),
    .command_i(drv_cmd.command), .u_pos_i(drv_cmd.u_pos), .v_pos_i(drv_cmd.v_pos),
    .radius_i(drv_cmd.radius), .depth_i(drv_cmd.depth),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .visible_o(visible_o), .occluder_source_o(occluder_source_o),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int eff_size(logic [10:0] r, int unsigned mx);
    if (r < 1) return 1;
    if (r > mx) return int'(mx);
    return int'(r);
  endfunction

  function automatic logic [31:0] read_z(bit dyn, int unsigned idx);
    if (dyn) return dynamic_z.exists(idx) ? dynamic_z[idx] : EmptyMark;
    return static_z.exists(idx) ? static_z[idx] : EmptyMark;
  endfunction

  function automatic void min_store(bit dyn, int unsigned idx, logic [31:0] d);
    if (d < read_z(dyn, idx)) begin
      if (dyn) dynamic_z[idx] = d;
      else static_z[idx] = d;
    end
  endfunction

  function automatic int ceil_px(int a);
    if (a <= 0) return -((-a) >>> 4);
    return (a + 15) >>> 4;
  endfunction

  function automatic bit depth_gate(logic [31:0] d, logic [31:0] z, logic [15:0] rel,
                                    logic [31:0] abs_tol);
    longint unsigned lhs, rhs;
    lhs = longint'(d) << 16;
    rhs = longint'(z) * (64'd65536 + longint'(rel)) + (longint'(abs_tol) << 16);
    return lhs <= rhs;
  endfunction

  function automatic void paint_disc(bit dyn, int w, int h, int u, int v, int r,
                                     logic [31:0] d);
    int x0, x1, y0, y1;
    longint dx, dy, rsq;
    min_store(dyn, (v >> 4) * w + (u >> 4), d);
    if (r <= 0) return;
    x0 = ceil_px(u - r); if (x0 < 0) x0 = 0;
    x1 = (u + r) >> 4;   if (x1 > w - 1) x1 = w - 1;
    y0 = ceil_px(v - r); if (y0 < 0) y0 = 0;
    y1 = (v + r) >> 4;   if (y1 > h - 1) y1 = h - 1;
    rsq = longint'(r) * r;
    for (int py = y0; py <= y1; py++) begin
      dy = longint'(py) * 16 - v;
      for (int px = x0; px <= x1; px++) begin
        dx = longint'(px) * 16 - u;
        if (dx * dx + dy * dy <= rsq) min_store(dyn, py * w + px, d);
      end
    end
  endfunction

  function automatic void apply_cmd(point_cmd_t c);
    int w, h, u, v;
    logic [31:0] d, z;
    vis_result_t res;
    bit on_img;
    w = eff_size(width_reg, MaxW);
    h = eff_size(height_reg, MaxH);
    u = int'(c.u_pos);
    v = int'(c.v_pos);
    d = (c.depth > EmptyMark - 1) ? EmptyMark - 1 : c.depth;
    on_img = (u >> 4) < w && (v >> 4) < h;
    case (c.command)
      dsvb_pkg::CMD_CLEAR: begin
        static_z.delete();
        dynamic_z.delete();
      end
      dsvb_pkg::CMD_SPLAT_STATIC, dsvb_pkg::CMD_SPLAT_DYNAMIC: begin
        if (on_img) paint_disc(c.command == dsvb_pkg::CMD_SPLAT_DYNAMIC, w, h, u, v,
                               c.radius, d);
      end
      default: begin
        res = '0;
        if (on_img) begin
          z = read_z(1'b1, (v >> 4) * w + (u >> 4));
          if (z != EmptyMark) begin
            res.visible = depth_gate(d, z, drel_reg, dabs_reg);
            res.occluder_source = 1'b1;
          end else begin
            z = read_z(1'b0, (v >> 4) * w + (u >> 4));
            res.visible = (z == EmptyMark) ? 1'b1 : depth_gate(d, z, srel_reg, sabs_reg);
          end
        end
        expected_vis.insert(expected_vis.size(), res);
      end
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) apply_cmd(drv_cmd);
      if (!in_valid || !in_stall_o) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
          drv_cmd <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    vis_result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_vis.size() == 0) begin
          $error("unexpected transaction: visible %0b source %0b", visible_o,
                 occluder_source_o);
          errors++;
        end else begin
          want = expected_vis.pop_front();
          if (visible_o !== want.visible) begin
            $error("visible: expected %0b actual %0b", want.visible, visible_o);
            errors++;
          end
          if (occluder_source_o !== want.occluder_source) begin
            $error("occluder_source: expected %0b actual %0b", want.occluder_source,
                   occluder_source_o);
            errors++;
          end
        end
      end
      if (rcv_hold > 0) begin
        rcv_hold <= rcv_hold - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle);
      end
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_vis.size() > 0 || in_stall_o)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(dsvb_pkg::cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      dsvb_pkg::CFG_IMAGE_WIDTH:     width_reg = val[10:0];
      dsvb_pkg::CFG_IMAGE_HEIGHT:    height_reg = val[10:0];
      dsvb_pkg::CFG_STATIC_REL_TOL:  srel_reg = val[15:0];
      dsvb_pkg::CFG_STATIC_ABS_TOL:  sabs_reg = val;
      dsvb_pkg::CFG_DYNAMIC_REL_TOL: drel_reg = val[15:0];
      default:                       dabs_reg = val;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_cmd(dsvb_pkg::cmd_e c, int u, int v, int r, logic [31:0] d);
    point_cmd_t p;
    p.command = c;
    p.u_pos = u[dsvb_pkg::CoordW-1:0];
    p.v_pos = v[dsvb_pkg::CoordW-1:0];
    p.radius = r[dsvb_pkg::RadiusW-1:0];
    p.depth = d;
    pending_cmds.insert(pending_cmds.size(), p);
  endtask

  function automatic logic [31:0] pick_tol(int bits);
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return (bits == 16) ? 32'hFFFF : 32'hFFFF_FFFE;
      2: return $urandom_range(0, 4096);
      default: return (bits == 16) ? {16'd0, 16'($urandom)} : $urandom;
    endcase
  endfunction

  task automatic random_setup();
    int sizes[6] = '{1, 16, 40, 1024, 0, 2047};
    write_reg(dsvb_pkg::CFG_IMAGE_WIDTH,
              (($urandom_range(0, 2) == 0) ? sizes[$urandom_range(0, 5)]
                                           : $urandom_range(1, 64)));
    write_reg(dsvb_pkg::CFG_IMAGE_HEIGHT,
              (($urandom_range(0, 2) == 0) ? sizes[$urandom_range(0, 5)]
                                           : $urandom_range(1, 64)));
    write_reg(dsvb_pkg::CFG_STATIC_REL_TOL, pick_tol(16));
    write_reg(dsvb_pkg::CFG_STATIC_ABS_TOL, pick_tol(32));
    write_reg(dsvb_pkg::CFG_DYNAMIC_REL_TOL, pick_tol(16));
    write_reg(dsvb_pkg::CFG_DYNAMIC_ABS_TOL, pick_tol(32));
  endtask

  task automatic random_batch(int n);
    int w, h, wl, hl, u, v, r, k;
    logic [31:0] d;
    w = eff_size(width_reg, MaxW);
    h = eff_size(height_reg, MaxH);
    wl = (w > 48) ? 48 : w;
    hl = (h > 48) ? 48 : h;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        u = $urandom_range(0, 16383);
        v = $urandom_range(0, 16383);
      end else begin
        u = $urandom_range(0, wl * 16 + 8);
        v = $urandom_range(0, hl * 16 + 8);
      end
      if (w <= 64 && h <= 64 && $urandom_range(0, 19) == 0) r = $urandom_range(0, 4095);
      else r = $urandom_range(0, 56);
      case ($urandom_range(0, 9))
        0: d = 32'hFFFF_FFFF;
        1: d = 32'd0;
        2: d = $urandom;
        default: d = $urandom_range(32'h0001_0000, 32'h0008_0000);
      endcase
      if (k < 45) push_cmd(dsvb_pkg::CMD_TEST, u, v, r, d);
      else if (k < 75) push_cmd(dsvb_pkg::CMD_SPLAT_STATIC, u, v, r, d);
      else push_cmd(dsvb_pkg::CMD_SPLAT_DYNAMIC, u, v, r, d);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(dsvb_pkg::CFG_IMAGE_WIDTH, 16);
    write_reg(dsvb_pkg::CFG_IMAGE_HEIGHT, 16);
    write_reg(dsvb_pkg::CFG_STATIC_REL_TOL, 32'hFFFF);
    write_reg(dsvb_pkg::CFG_STATIC_ABS_TOL, 32'd0);
    write_reg(dsvb_pkg::CFG_DYNAMIC_REL_TOL, 32'd0);
    write_reg(dsvb_pkg::CFG_DYNAMIC_ABS_TOL, 32'hFFFF_FFFE);
    push_cmd(dsvb_pkg::CMD_TEST, 0, 0, 0, 32'd5);
    push_cmd(dsvb_pkg::CMD_SPLAT_STATIC, 0, 0, 0, 32'd0);
    push_cmd(dsvb_pkg::CMD_TEST, 0, 0, 0, 32'd0);
    push_cmd(dsvb_pkg::CMD_TEST, 0, 0, 0, 32'hFFFF_FFFF);
    push_cmd(dsvb_pkg::CMD_SPLAT_STATIC, 8 * 16 + 8, 8 * 16 + 8, 4095, 32'hFFFF_FFFF);
    push_cmd(dsvb_pkg::CMD_TEST, 15 * 16 + 15, 15 * 16 + 15, 0, 32'hFFFF_FFFF);
    push_cmd(dsvb_pkg::CMD_SPLAT_DYNAMIC, 16383, 16383, 4095, 32'd1);
    push_cmd(dsvb_pkg::CMD_TEST, 16383, 16383, 0, 32'd1);
    push_cmd(dsvb_pkg::CMD_TEST, 16 * 16, 0, 0, 32'd1);
    push_cmd(dsvb_pkg::CMD_SPLAT_DYNAMIC, 5 * 16, 5 * 16, 40, 32'h0002_0000);
    push_cmd(dsvb_pkg::CMD_TEST, 7 * 16, 5 * 16, 0, 32'hFFFF_FFFE);
    push_cmd(dsvb_pkg::CMD_TEST, 8 * 16, 5 * 16, 0, 32'h0003_0000);
    push_cmd(dsvb_pkg::CMD_SPLAT_STATIC, 3 * 16 + 7, 2 * 16 + 9, 4095, 32'h0001_0000);
    push_cmd(dsvb_pkg::CMD_TEST, 3 * 16, 2 * 16, 0, 32'h0001_0000);
    drain();
    write_reg(dsvb_pkg::CFG_IMAGE_WIDTH, 0);
    write_reg(dsvb_pkg::CFG_IMAGE_HEIGHT, 2047);
    push_cmd(dsvb_pkg::CMD_TEST, 0, 16 * 16, 0, 32'h0001_0000);
    push_cmd(dsvb_pkg::CMD_TEST, 16, 0, 0, 32'h0001_0000);
    push_cmd(dsvb_pkg::CMD_SPLAT_DYNAMIC, 0, 1023 * 16 + 15, 33, 32'd7);
    push_cmd(dsvb_pkg::CMD_TEST, 0, 1023 * 16, 0, 32'd7);
    push_cmd(dsvb_pkg::CMD_CLEAR, 16383, 16383, 4095, 32'hFFFF_FFFF);
    push_cmd(dsvb_pkg::CMD_TEST, 0, 1023 * 16, 0, 32'd7);
    push_cmd(dsvb_pkg::CMD_TEST, 0, 0, 0, 32'd9);
    drain();

    for (int b = 0; b < 6; b++) begin
      if (b < 2) begin snd_idle = 34; rcv_idle = 73; end
      else if (b < 4) begin snd_idle = 73; rcv_idle = 34; end
      else begin snd_idle = 0; rcv_idle = 0; end
      random_setup();
      if (b == 4) rcv_hold = 3000;
      random_batch(190);
      drain();
    end

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
rtl/core/dsvb_pkg.sv
rtl/core/dsvb_gate.sv
rtl/core/depth_splat_visibility_buffer.sv
rtl/core/dsvb_checker.sv
dv/tb_depth_splat_visibility_buffer.sv
